>>> hw/rtl/wat_pkg.sv
// ----------------------------------------------------------------------------
// Weekly alarm table package
// Entry layout, operation codes and sequencer states shared by the alarm
// table cells, the table controller and the top level.
// ----------------------------------------------------------------------------
package wat_pkg;

    localparam int HOURS_W   = 5;
    localparam int MINUTES_W = 6;
    localparam int DAYS_W    = 7;
    localparam int WEEKDAY_W = 3;
    localparam int OP_W      = 3;

    localparam logic [WEEKDAY_W-1:0] SUNDAY     = 3'd0;
    localparam logic [WEEKDAY_W-1:0] WEEKDAY_HI = 3'd6;
    localparam int                   SUNDAY_BIT = 6;

    typedef struct packed {
        logic                 enabled;
        logic                 even_weeks;
        logic                 odd_weeks;
        logic [DAYS_W-1:0]    day_mask;
        logic [MINUTES_W-1:0] minutes;
        logic [HOURS_W-1:0]   hours;
    } alarm_entry_t;

    typedef enum logic [OP_W-1:0] {
        OP_CHECK  = 3'd0,
        OP_ADD    = 3'd1,
        OP_REMOVE = 3'd2,
        OP_SET_EN = 3'd3,
        OP_QUERY  = 3'd4
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_SCAN = 2'd1,
        ST_HOLD = 2'd2
    } state_t;

endpackage

>>> hw/rtl/wat_cell.sv
// ----------------------------------------------------------------------------
// Alarm table cell
// Holds one table entry and takes the entry of its neighbor while the ring
// is rotating.
// ----------------------------------------------------------------------------
module wat_cell (
    input  logic                  clk,
    input  logic                  shift_en,
    input  wat_pkg::alarm_entry_t entry_in,
    output wat_pkg::alarm_entry_t entry_out
);
    import wat_pkg::*;

    alarm_entry_t entry_reg;
    alarm_entry_t entry_next;

    always_comb
    begin
        entry_next = shift_en ? entry_in : entry_reg;
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry_out = entry_reg;

endmodule

>>> hw/rtl/wat_ctrl.sv
// ----------------------------------------------------------------------------
// Alarm table controller
// Takes one beat, rotates the cell ring once around, edits or inspects the
// entry passing the head, and returns one result beat.
// ----------------------------------------------------------------------------
module wat_ctrl #(
    parameter int MAX_ALARMS = 64,
    parameter int CNT_W      = 7,
    parameter int IDX_W      = 6
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [wat_pkg::OP_W-1:0]        operation,
    input  logic [CNT_W-1:0]                slot,
    input  wat_pkg::alarm_entry_t           new_entry,
    input  logic [wat_pkg::HOURS_W-1:0]     now_hours,
    input  logic [wat_pkg::MINUTES_W-1:0]   now_minutes,
    input  logic [wat_pkg::WEEKDAY_W-1:0]   now_day_of_week,
    input  logic                            now_odd_week,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic                            alarm_running,
    output logic                            entry_enabled,
    output logic [CNT_W-1:0]                entry_count,
    output logic                            refused,
    output logic                            shift_en,
    input  wat_pkg::alarm_entry_t           head_entry,
    input  wat_pkg::alarm_entry_t           second_entry,
    output wat_pkg::alarm_entry_t           tail_entry
);
    import wat_pkg::*;

    state_t                 state_reg, state_next;
    logic [IDX_W-1:0]       step_reg, step_next;
    logic [CNT_W-1:0]       total_reg, total_next;
    logic [OP_W-1:0]        op_reg, op_next;
    logic [CNT_W-1:0]       slot_reg, slot_next;
    alarm_entry_t           new_reg, new_next;
    logic [HOURS_W-1:0]     now_h_reg, now_h_next;
    logic [MINUTES_W-1:0]   now_m_reg, now_m_next;
    logic [WEEKDAY_W-1:0]   now_d_reg, now_d_next;
    logic                   now_odd_reg, now_odd_next;
    logic                   refused_reg, refused_next;
    logic                   running_reg, running_next;
    logic                   enabled_reg, enabled_next;
    logic                   out_valid_reg, out_valid_next;
    logic                   out_running_reg, out_running_next;
    logic                   out_enabled_reg, out_enabled_next;
    logic [CNT_W-1:0]       out_count_reg, out_count_next;
    logic                   out_refused_reg, out_refused_next;

    logic                   accept;
    logic                   out_free;
    logic                   slot_ok;
    logic [CNT_W-1:0]       step_ext;
    logic [CNT_W-1:0]       slot_idx;
    logic                   at_slot;
    logic                   day_hit;
    logic                   head_match;
    logic                   last_step;

    assign accept   = in_valid && (state_reg == ST_IDLE);
    assign out_free = !out_valid_reg || !out_stall;
    assign slot_ok  = (slot != '0) && (slot <= total_reg);
    assign step_ext = CNT_W'(step_reg);
    assign slot_idx = slot_reg - CNT_W'(1);
    assign at_slot  = (step_ext == slot_idx);
    assign last_step = (step_reg == IDX_W'(MAX_ALARMS - 1));

    always_comb
    begin
        if ((now_d_reg == SUNDAY) || (now_d_reg > WEEKDAY_HI))
        begin
            day_hit = head_entry.day_mask[SUNDAY_BIT];
        end
        else
        begin
            day_hit = head_entry.day_mask[now_d_reg - WEEKDAY_W'(1)];
        end
        head_match = head_entry.enabled
                     && (head_entry.hours == now_h_reg)
                     && (head_entry.minutes == now_m_reg)
                     && (now_odd_reg ? head_entry.odd_weeks : head_entry.even_weeks)
                     && day_hit;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            total_reg     <= total_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg          <= op_next;
        slot_reg        <= slot_next;
        new_reg         <= new_next;
        now_h_reg       <= now_h_next;
        now_m_reg       <= now_m_next;
        now_d_reg       <= now_d_next;
        now_odd_reg     <= now_odd_next;
        refused_reg     <= refused_next;
        running_reg     <= running_next;
        enabled_reg     <= enabled_next;
        out_running_reg <= out_running_next;
        out_enabled_reg <= out_enabled_next;
        out_count_reg   <= out_count_next;
        out_refused_reg <= out_refused_next;
    end

    always_comb
    begin
        state_next       = state_reg;
        step_next        = step_reg;
        total_next       = total_reg;
        op_next          = op_reg;
        slot_next        = slot_reg;
        new_next         = new_reg;
        now_h_next       = now_h_reg;
        now_m_next       = now_m_reg;
        now_d_next       = now_d_reg;
        now_odd_next     = now_odd_reg;
        refused_next     = refused_reg;
        running_next     = running_reg;
        enabled_next     = enabled_reg;
        out_valid_next   = out_valid_reg && out_stall;
        out_running_next = out_running_reg;
        out_enabled_next = out_enabled_reg;
        out_count_next   = out_count_reg;
        out_refused_next = out_refused_reg;
        tail_entry       = head_entry;
        shift_en         = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    op_next      = operation;
                    slot_next    = slot;
                    new_next     = new_entry;
                    now_h_next   = now_hours;
                    now_m_next   = now_minutes;
                    now_d_next   = now_day_of_week;
                    now_odd_next = now_odd_week;
                    running_next = 1'b0;
                    enabled_next = 1'b0;
                    step_next    = '0;
                    case (operation) inside
                        OP_CHECK:
                            refused_next = 1'b0;
                        OP_ADD:
                            refused_next = (total_reg >= CNT_W'(MAX_ALARMS));
                        OP_REMOVE, OP_SET_EN, OP_QUERY:
                            refused_next = !slot_ok;
                        default:
                            refused_next = 1'b1;
                    endcase
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                shift_en = 1'b1;
                if (!refused_reg)
                begin
                    case (op_reg)
                        OP_CHECK:
                        begin
                            if ((step_ext < total_reg) && head_match)
                            begin
                                running_next = 1'b1;
                            end
                        end
                        OP_ADD:
                        begin
                            if (step_ext == total_reg)
                            begin
                                tail_entry = new_reg;
                            end
                        end
                        OP_REMOVE:
                        begin
                            if (step_ext >= slot_idx)
                            begin
                                tail_entry = second_entry;
                            end
                        end
                        OP_SET_EN:
                        begin
                            if (at_slot)
                            begin
                                tail_entry.enabled = new_reg.enabled;
                            end
                        end
                        OP_QUERY:
                        begin
                            if (at_slot)
                            begin
                                enabled_next = head_entry.enabled;
                            end
                        end
                        default:
                        begin
                            tail_entry = head_entry;
                        end
                    endcase
                end
                if (last_step)
                begin
                    if (!refused_reg && (op_reg == OP_ADD))
                    begin
                        total_next = total_reg + CNT_W'(1);
                    end
                    else if (!refused_reg && (op_reg == OP_REMOVE))
                    begin
                        total_next = total_reg - CNT_W'(1);
                    end
                    state_next = ST_HOLD;
                end
                else
                begin
                    step_next = step_reg + IDX_W'(1);
                end
            end
            ST_HOLD:
            begin
                if (out_free)
                begin
                    out_valid_next   = 1'b1;
                    out_running_next = running_reg;
                    out_enabled_next = enabled_reg;
                    out_count_next   = total_reg;
                    out_refused_next = refused_reg;
                    state_next       = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign in_stall      = (state_reg != ST_IDLE);
    assign out_valid     = out_valid_reg;
    assign alarm_running = out_running_reg;
    assign entry_enabled = out_enabled_reg;
    assign entry_count   = out_count_reg;
    assign refused       = out_refused_reg;

endmodule

>>> hw/rtl/weekly_alarm_table_matcher_unit.sv
// ----------------------------------------------------------------------------
// Weekly alarm table matcher
// A packed table of alarm entries kept in a ring of cells, with add, remove,
// set enable, query enable and time check operations.
// ----------------------------------------------------------------------------
//  beat     handshake              payload
//  input    in_valid / in_stall    operation, slot, alarm_*, now_*
//  output   out_valid / out_stall  alarm_running, entry_enabled, entry_count,
//                                  refused
//
// Every input beat is captured, then the ring of MAX_ALARMS cells makes one full
// rotation, and then the result is loaded into the output register once that
// register is free.
// Reset clears the entry count and the control state; the cells are not reset.
// A stalled result waits in the output register while the next beat is taken.
// ----------------------------------------------------------------------------
module weekly_alarm_table_matcher_unit #(
    parameter  int MAX_ALARMS = 64,
    localparam int CNT_W      = $clog2(MAX_ALARMS + 1),
    localparam int IDX_W      = (MAX_ALARMS > 1) ? $clog2(MAX_ALARMS) : 1
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [wat_pkg::OP_W-1:0]      operation,
    input  logic [CNT_W-1:0]              slot,
    input  logic [wat_pkg::HOURS_W-1:0]   alarm_hours,
    input  logic [wat_pkg::MINUTES_W-1:0] alarm_minutes,
    input  logic [wat_pkg::DAYS_W-1:0]    alarm_day_mask,
    input  logic                          alarm_odd_weeks,
    input  logic                          alarm_even_weeks,
    input  logic                          alarm_enabled,
    input  logic [wat_pkg::HOURS_W-1:0]   now_hours,
    input  logic [wat_pkg::MINUTES_W-1:0] now_minutes,
    input  logic [wat_pkg::WEEKDAY_W-1:0] now_day_of_week,
    input  logic                          now_odd_week,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          alarm_running,
    output logic                          entry_enabled,
    output logic [CNT_W-1:0]              entry_count,
    output logic                          refused
);
    import wat_pkg::*;

    localparam int SECOND_IDX = (MAX_ALARMS > 1) ? 1 : 0;

    alarm_entry_t ring [MAX_ALARMS];
    alarm_entry_t new_entry;
    alarm_entry_t tail_entry;
    logic         shift_en;

    always_comb
    begin
        new_entry.enabled    = alarm_enabled;
        new_entry.even_weeks = alarm_even_weeks;
        new_entry.odd_weeks  = alarm_odd_weeks;
        new_entry.day_mask   = alarm_day_mask;
        new_entry.minutes    = alarm_minutes;
        new_entry.hours      = alarm_hours;
    end

    for (genvar i = 0; i < MAX_ALARMS; i++)
    begin : g_cell
        alarm_entry_t cell_in;
        if (i == MAX_ALARMS - 1)
        begin : g_tail
            assign cell_in = tail_entry;
        end
        else
        begin : g_link
            assign cell_in = ring[i + 1];
        end
        wat_cell u_cell (
            .clk       (clk),
            .shift_en  (shift_en),
            .entry_in  (cell_in),
            .entry_out (ring[i])
        );
    end

    wat_ctrl #(
        .MAX_ALARMS (MAX_ALARMS),
        .CNT_W      (CNT_W),
        .IDX_W      (IDX_W)
    ) u_ctrl (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .operation       (operation),
        .slot            (slot),
        .new_entry       (new_entry),
        .now_hours       (now_hours),
        .now_minutes     (now_minutes),
        .now_day_of_week (now_day_of_week),
        .now_odd_week    (now_odd_week),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .alarm_running   (alarm_running),
        .entry_enabled   (entry_enabled),
        .entry_count     (entry_count),
        .refused         (refused),
        .shift_en        (shift_en),
        .head_entry      (ring[0]),
        .second_entry    (ring[SECOND_IDX]),
        .tail_entry      (tail_entry)
    );

endmodule
